// ===== design/tdss_pkg.sv =====
// Package for the three-digit seven-segment serializer.
// Holds shared widths, divide-by-ten constants and the segment pattern tables.
// No dependencies.
package tdss_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned SEG_WORD_W  = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAX_SENT    = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Reciprocal of ten: exact for 16-bit values with a shift of 19,
  // and for values up to 1028 with the narrow form and a shift of 11.
  localparam logic [15:0] RECIP10_WIDE   = 16'hCCCD;
  localparam logic [7:0]  RECIP10_NARROW = 8'd205;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [15:0]        seg_t;

  // Pattern for displays 1 and 3: PCDE--------GFAB
  function automatic seg_t seg_outer(input digit_t digit);
    seg_t pat;
    case (digit)
      4'd0:    pat = 16'h7007;
      4'd1:    pat = 16'h4001;
      4'd2:    pat = 16'h300B;
      4'd3:    pat = 16'h600B;
      4'd4:    pat = 16'h400D;
      4'd5:    pat = 16'h600E;
      4'd6:    pat = 16'h700E;
      4'd7:    pat = 16'h4003;
      4'd8:    pat = 16'h700F;
      4'd9:    pat = 16'h600F;
      default: pat = 16'h0000;
    endcase
    return pat;
  endfunction

  // Pattern for display 2: ----PCDEGFAB----
  function automatic seg_t seg_middle(input digit_t digit);
    seg_t pat;
    case (digit)
      4'd0:    pat = 16'h0770;
      4'd1:    pat = 16'h0410;
      4'd2:    pat = 16'h03B0;
      4'd3:    pat = 16'h06B0;
      4'd4:    pat = 16'h04D0;
      4'd5:    pat = 16'h06E0;
      4'd6:    pat = 16'h07E0;
      4'd7:    pat = 16'h0430;
      4'd8:    pat = 16'h07F0;
      4'd9:    pat = 16'h06F0;
      default: pat = 16'h0000;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/tdss_if.sv =====
// Channel interfaces for the serializer: item input, internal word queue
// channel and serial bit output. Depends on tdss_pkg.
interface tdss_item_if import tdss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [VALUE_W-1:0]    decimal_value;
  logic [SEG_WORD_W-1:0] raw_word;

  modport source (output valid, action, decimal_value, raw_word, input ready);
  modport sink   (input valid, action, decimal_value, raw_word, output ready);
endinterface

interface tdss_word_if #(parameter int unsigned WIDTH = 32) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] word;

  modport source (output valid, word, input ready);
  modport sink   (input valid, word, output ready);
endinterface

interface tdss_bit_if import tdss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             serial_bit;
  logic [POS_W-1:0] bit_position;
  logic             latch_after;

  modport source (output valid, serial_bit, bit_position, latch_after, input ready);
  modport sink   (input valid, serial_bit, bit_position, latch_after, output ready);
endinterface

// ===== design/tdss_front.sv =====
// Front end: accepts items, splits the number into three decimal digits and
// builds the segment word; raw words pass. Depends on tdss_pkg and tdss_if.
module tdss_front import tdss_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  tdss_item_if.sink   item,
  tdss_word_if.source word_out
);

  localparam int unsigned SENT_BITS = (WORD_BITS > MAX_SENT) ? MAX_SENT : WORD_BITS;

  // Stage A registers
  logic                  va;
  logic                  act_a;
  logic [SEG_WORD_W-1:0] raw_a;
  logic [VALUE_W-1:0]    num_a;
  logic [12:0]           q1_a;

  // Stage B registers
  logic                  vb;
  logic                  act_b;
  logic [SEG_WORD_W-1:0] raw_b;
  digit_t                units_b;
  logic [12:0]           q1_b;
  logic [9:0]            q2_b;

  logic        ready_a;
  logic        ready_b;
  logic [31:0] prod_in;
  logic [31:0] prod_a;
  logic [15:0] ten_q1;
  logic [15:0] units_diff;
  logic [17:0] prod_b;
  logic [6:0]  q3;
  logic [12:0] ten_q2;
  logic [12:0] tens_diff;
  logic [9:0]  ten_q3;
  logic [9:0]  hund_diff;
  digit_t      tens;
  digit_t      hund;
  logic [SEG_WORD_W-1:0] seg_word;
  logic [SEG_WORD_W-1:0] full_word;

  // Stall handshake back through the stages
  assign ready_b    = !vb || word_out.ready;
  assign ready_a    = !va || ready_b;
  assign item.ready = ready_a;

  // First divide by ten on the incoming value
  assign prod_in = 32'(item.decimal_value) * 32'(RECIP10_WIDE);

  // Stage A: units digit and second divide by ten
  assign ten_q1     = {q1_a, 3'b000} + {2'b00, q1_a, 1'b0};
  assign units_diff = num_a - ten_q1;
  assign prod_a     = 32'({3'b000, q1_a}) * 32'(RECIP10_WIDE);

  // Stage B: tens and hundreds digits, table lookup and merge
  assign ten_q2    = {q2_b, 3'b000} + {2'b00, q2_b, 1'b0};
  assign tens_diff = q1_b - ten_q2;
  assign tens      = tens_diff[DIGIT_W-1:0];
  assign prod_b    = 18'(q2_b) * 18'(RECIP10_NARROW);
  assign q3        = prod_b[17:11];
  assign ten_q3    = {q3, 3'b000} + {2'b00, q3, 1'b0};
  assign hund_diff = q2_b - ten_q3;
  assign hund      = hund_diff[DIGIT_W-1:0];

  assign seg_word  = {seg_outer(hund), 16'h0000}
                   | {16'h0000, seg_middle(tens)}
                   | {16'h0000, seg_outer(units_b)};
  assign full_word = act_b ? raw_b : seg_word;

  assign word_out.valid = vb;
  assign word_out.word  = full_word[SENT_BITS-1:0];

  // Advance the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) begin
        va <= item.valid;
      end
      if (ready_b) begin
        vb <= va;
      end
    end
    if (ready_a && item.valid) begin
      act_a <= item.action;
      raw_a <= item.raw_word;
      num_a <= item.decimal_value;
      q1_a  <= prod_in[31:19];
    end
    if (ready_b && va) begin
      act_b   <= act_a;
      raw_b   <= raw_a;
      units_b <= units_diff[DIGIT_W-1:0];
      q1_b    <= q1_a;
      q2_b    <= prod_a[28:19];
    end
  end

endmodule

// ===== design/tdss_queue.sv =====
// Two-entry word queue between front and back end.
// Depends on tdss_pkg and tdss_if.
module tdss_queue import tdss_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  tdss_word_if.sink   wr,
  tdss_word_if.source rd
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.word  = entries[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= wr.word;
    end
  end

endmodule

// ===== design/tdss_back.sv =====
// Back end: shifts each queued word out LSB first, one bit per transaction,
// and marks the last bit for the latch. Depends on tdss_pkg and tdss_if.
module tdss_back import tdss_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  tdss_word_if.sink   word_in,
  tdss_bit_if.source  serial
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WIDTH - 1);

  logic             busy;
  logic [WIDTH-1:0] shreg;
  logic [POS_W-1:0] pos;
  logic             last;
  logic             take;

  assign last = (pos == LAST_POS);
  assign take = !busy || (serial.ready && last);

  assign word_in.ready       = take;
  assign serial.valid        = busy;
  assign serial.serial_bit   = shreg[0];
  assign serial.bit_position = pos;
  assign serial.latch_after  = last;

  // Shift on each accepted bit, load the next word after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (busy && serial.ready && !last) begin
      shreg <= shreg >> 1;
      pos   <= pos + 1'b1;
    end else if (take) begin
      busy <= word_in.valid;
      pos  <= '0;
      if (word_in.valid) begin
        shreg <= word_in.word;
      end
    end
  end

endmodule

// ===== design/three_digit_seven_segment_serializer_unit.sv =====
// Three-digit seven-segment serializer. Each item carries either a number,
// whose lowest three decimal digits become one segment word, or a raw word.
// The word goes out LSB first as min(WORD_BITS, 32) serial bit transactions,
// one per cycle while the output is ready, with the last bit marked for the
// latch pulse. The bit serializer sets the item rate and loads the next word
// as the last bit of the previous one is taken. The first bit of an item
// passes the two front stages, the queue and the back-end shift register; a
// two-entry queue lets the front keep accepting items while a word shifts out.
// Depends on tdss_pkg, tdss_if, tdss_front, tdss_queue and tdss_back.
module three_digit_seven_segment_serializer_unit import tdss_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  tdss_item_if.sink  item,
  tdss_bit_if.source serial
);

  localparam int unsigned SENT_BITS = (WORD_BITS > MAX_SENT) ? MAX_SENT : WORD_BITS;

  tdss_word_if #(.WIDTH(SENT_BITS)) front_word ();
  tdss_word_if #(.WIDTH(SENT_BITS)) back_word ();

  // Digit split and word build
  tdss_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .word_out (front_word)
  );

  // Decouple front and back
  tdss_queue #(.WIDTH(SENT_BITS)) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_word),
    .rd  (back_word)
  );

  // Serial shift out
  tdss_back #(.WIDTH(SENT_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .word_in (back_word),
    .serial  (serial)
  );

endmodule
